### design/sirs_pkg.sv
// shared types, constants and the digit table for the radix string converter
// no dependencies
package sirs_pkg;

    // legal base range
    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;

    // ascii minus sign
    localparam logic [6:0] MINUS_CODE = 7'h2D;

    // dividend bits handled per divider step
    localparam int CHUNK_BITS = 8;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // what the front end learns about one item
    typedef struct packed {
        logic [4:0] radix;
        logic       neg;
        logic       bad;
    } t_cls;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT,
        ST_ERR
    } t_back_state;

    // digit value to ascii
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        case (d)
            4'h0:    c = 7'h30;
            4'h1:    c = 7'h31;
            4'h2:    c = 7'h32;
            4'h3:    c = 7'h33;
            4'h4:    c = 7'h34;
            4'h5:    c = 7'h35;
            4'h6:    c = 7'h36;
            4'h7:    c = 7'h37;
            4'h8:    c = 7'h38;
            4'h9:    c = 7'h39;
            4'hA:    c = 7'h41;
            4'hB:    c = 7'h42;
            4'hC:    c = 7'h43;
            4'hD:    c = 7'h44;
            4'hE:    c = 7'h45;
            default: c = 7'h46;
        endcase
        return c;
    endfunction

endpackage

### design/sirs_if.sv
// valid/ready channel interfaces for the radix string converter
// no dependencies
interface sirs_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [4:0]            radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface sirs_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;
    logic       bad_radix;

    modport source (output valid, output char_code, output last_char, output bad_radix,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input bad_radix,
                    output ready);
endinterface

### design/sirs_front.sv
// front end: takes input beats, checks the base, splits sign and magnitude
// depends on sirs_pkg and sirs_in_if
module sirs_front #(
    parameter int VALUE_BITS = 32
) (
    sirs_in_if.sink               i_in,
    input  logic                  i_q_ready,
    output logic                  o_q_valid,
    output logic [VALUE_BITS-1:0] o_q_mag,
    output sirs_pkg::t_cls        o_q_cls
);

    logic neg;

    // handshake passes straight into the queue
    assign o_q_valid = i_in.valid;
    assign i_in.ready = i_q_ready;

    // classification
    assign neg = i_in.value[VALUE_BITS-1];
    assign o_q_mag = neg ? (~i_in.value + VALUE_BITS'(1)) : i_in.value;

    always_comb begin
        o_q_cls.radix = i_in.radix;
        o_q_cls.neg   = neg;
        o_q_cls.bad   = !(i_in.radix inside {[sirs_pkg::RADIX_MIN:sirs_pkg::RADIX_MAX]});
    end

endmodule

### design/sirs_queue.sv
// short fifo decoupling the front end from the back end
// depends on sirs_pkg
module sirs_queue #(
    parameter int WIDTH = 39
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (sirs_pkg::QUEUE_DEPTH > 1) ? $clog2(sirs_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(sirs_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [sirs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(sirs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(sirs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(sirs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        n_count = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### design/sirs_back.sv
// back end: digit divider, digit buffer and character output register
// depends on sirs_pkg and sirs_out_if
module sirs_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  logic [VALUE_BITS-1:0] i_q_mag,
    input  sirs_pkg::t_cls        i_q_cls,
    sirs_out_if.source            o_out
);

    localparam int CB     = sirs_pkg::CHUNK_BITS;
    localparam int NCHUNK = (VALUE_BITS + CB - 1) / CB;
    localparam int W      = NCHUNK * CB;
    localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IW     = $clog2(VALUE_BITS);
    localparam int NW     = $clog2(VALUE_BITS + 1);

    sirs_pkg::t_back_state r_state, n_state;

    logic [W-1:0]    r_work, n_work;
    logic [3:0]      r_rem, n_rem;
    logic [KW-1:0]   r_chunk, n_chunk;
    logic [4:0]      r_radix, n_radix;
    logic            r_neg, n_neg;
    logic [NW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_idx, n_idx;
    logic [3:0]      r_rd_data;
    logic [3:0]      r_digits [VALUE_BITS];
    logic            wr_en;

    logic            r_out_valid, n_out_valid;
    logic [6:0]      r_char, n_char;
    logic            r_last, n_last;
    logic            r_bad, n_bad;

    logic            slot_free;
    logic            last_chunk;
    logic [3:0]      d_rem;
    logic [CB-1:0]   d_qbits;
    logic [W-1:0]    d_work;
    logic            d_zero;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign last_chunk = (r_chunk == KW'(NCHUNK - 1));
    assign o_q_pop    = (r_state == sirs_pkg::ST_IDLE) && i_q_valid;

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;
    assign o_out.bad_radix = r_bad;

    // one chunk of restoring division by the base, remainder stays below 16
    always_comb begin
        logic [3:0] rem;
        logic [4:0] t;
        rem = r_rem;
        d_qbits = '0;
        for (int k = 0; k < CB; k++) begin
            t = {rem, r_work[W-1-k]};
            if (t >= r_radix) begin
                d_qbits[CB-1-k] = 1'b1;
                rem = 4'(t - r_radix);
            end else begin
                rem = t[3:0];
            end
        end
        d_rem  = rem;
        d_work = (r_work << CB) | W'(d_qbits);
        d_zero = (d_work == '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sirs_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_cls.bad ? sirs_pkg::ST_ERR : sirs_pkg::ST_DIV;
                end
            end
            sirs_pkg::ST_DIV: begin
                if (last_chunk && d_zero) begin
                    n_state = sirs_pkg::ST_SIGN;
                end
            end
            sirs_pkg::ST_SIGN: begin
                if (!r_neg || slot_free) begin
                    n_state = sirs_pkg::ST_EMIT;
                end
            end
            sirs_pkg::ST_EMIT: begin
                if (slot_free && r_idx == '0) begin
                    n_state = sirs_pkg::ST_IDLE;
                end
            end
            sirs_pkg::ST_ERR: begin
                if (slot_free) begin
                    n_state = sirs_pkg::ST_IDLE;
                end
            end
            default: n_state = sirs_pkg::ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        n_work      = r_work;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_radix     = r_radix;
        n_neg       = r_neg;
        n_count     = r_count;
        n_idx       = r_idx;
        wr_en       = 1'b0;
        n_out_valid = o_out.ready ? 1'b0 : r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_bad       = r_bad;
        case (r_state)
            sirs_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_work  = W'(i_q_mag);
                    n_rem   = '0;
                    n_chunk = '0;
                    n_radix = i_q_cls.radix;
                    n_neg   = i_q_cls.neg;
                    n_count = '0;
                end
            end
            sirs_pkg::ST_DIV: begin
                n_work = d_work;
                if (last_chunk) begin
                    wr_en   = 1'b1;
                    n_rem   = '0;
                    n_chunk = '0;
                    n_count = r_count + NW'(1);
                    n_idx   = r_count[IW-1:0];
                end else begin
                    n_rem   = d_rem;
                    n_chunk = r_chunk + KW'(1);
                end
            end
            sirs_pkg::ST_SIGN: begin
                if (r_neg && slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sirs_pkg::MINUS_CODE;
                    n_last      = 1'b0;
                    n_bad       = 1'b0;
                end
            end
            sirs_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = sirs_pkg::digit_char(r_rd_data);
                    n_last      = (r_idx == '0);
                    n_bad       = 1'b0;
                    if (r_idx != '0) begin
                        n_idx = r_idx - IW'(1);
                    end
                end
            end
            sirs_pkg::ST_ERR: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = '0;
                    n_last      = 1'b1;
                    n_bad       = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sirs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_chunk     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chunk     <= n_chunk;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_neg       <= n_neg;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_char  <= n_char;
        r_last  <= n_last;
        r_bad   <= n_bad;
    end

    // digit buffer, least significant digit first, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_digits[r_count[IW-1:0]] <= d_rem;
        end
        r_rd_data <= r_digits[n_idx];
    end

endmodule

### design/signed_integer_to_radix_string.sv
// top level of the signed integer to radix ascii converter
// depends on sirs_pkg, sirs_if, sirs_front, sirs_queue and sirs_back
//
//  channel  dir  fields                                 beat
//  i_in     in   value[VALUE_BITS-1:0], radix[4:0]      one integer to convert
//  o_out    out  char_code[6:0], last_char, bad_radix   one ascii character
//
// an item leaves the queue from the idle state; the shared divider then finds its digits
// one by one (eight dividend bits a cycle), the sign state emits a minus sign only for a
// value < 0, and the digits leave the buffer; a bad base gets one beat from the error state.
// reset is synchronous, active low, and clears control state only.
// a two-entry queue takes new integers while the back end works; the output register
// holds a character until the sink takes it, stalling the sign, digit and error states.
module signed_integer_to_radix_string #(
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sirs_in_if.sink    i_in,
    sirs_out_if.source o_out
);

    localparam int QW = VALUE_BITS + $bits(sirs_pkg::t_cls);

    logic                  f_valid;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic [VALUE_BITS-1:0] f_mag;
    sirs_pkg::t_cls        f_cls;
    logic [QW-1:0]         q_data;
    logic [VALUE_BITS-1:0] b_mag;
    sirs_pkg::t_cls        b_cls;

    // front end
    sirs_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_in      (i_in),
        .i_q_ready (!q_full),
        .o_q_valid (f_valid),
        .o_q_mag   (f_mag),
        .o_q_cls   (f_cls)
    );

    // queue between the two halves
    sirs_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_cls, f_mag}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign b_mag = q_data[VALUE_BITS-1:0];
    assign b_cls = q_data[QW-1:VALUE_BITS];

    // back end
    sirs_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_empty),
        .o_q_pop   (q_pop),
        .i_q_mag   (b_mag),
        .i_q_cls   (b_cls),
        .o_out     (o_out)
    );

endmodule

### sim/signed_integer_to_radix_string_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the signed integer to radix ascii converter
// depends on sirs_pkg, sirs_if and the signed_integer_to_radix_string design files
module signed_integer_to_radix_string_test;

    localparam int VALUE_BITS  = 32;
    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 456;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 200;
    localparam int IDLE_LIMIT  = 4000;
    localparam int MAX_REPORTS = 10;

    // one character beat as the sink sees it
    typedef struct packed {
        logic [6:0] code;
        logic       last;
        logic       bad;
    } t_char_beat;

    // one directed integer; typed rows carry their text, an empty text means a bad base
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [4:0]            radix;
        bit                    typed;
        string                 text;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sirs_in_if #(.VALUE_BITS(VALUE_BITS)) num_ch ();
    sirs_out_if                           txt_ch ();

    signed_integer_to_radix_string #(.VALUE_BITS(VALUE_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_ch),
        .o_out   (txt_ch)
    );

    t_char_beat pending_chars [$];
    int         mismatches   = 0;
    int         chars_seen   = 0;
    int         ints_sent    = 0;
    int         bad_sent     = 0;
    int         idle_cycles  = 0;
    bit         calm         = 1'b0;
    bit         hold_req     = 1'b0;
    bit         hold_done    = 1'b0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{32'd0,        5'd10, 1'b1, "0"},
        '{32'd0,        5'd2,  1'b1, "0"},
        '{32'd0,        5'd16, 1'b1, "0"},
        '{32'h7FFFFFFF, 5'd16, 1'b1, "7FFFFFFF"},
        '{32'h7FFFFFFF, 5'd10, 1'b1, "2147483647"},
        '{32'h80000000, 5'd16, 1'b1, "-80000000"},
        '{32'h80000000, 5'd10, 1'b1, "-2147483648"},
        '{32'h80000000, 5'd8,  1'b1, "-20000000000"},
        '{32'h80000000, 5'd2,  1'b0, ""},
        '{32'h7FFFFFFF, 5'd2,  1'b0, ""},
        '{32'h7FFFFFFF, 5'd3,  1'b0, ""},
        '{32'hFFFFFFFF, 5'd2,  1'b1, "-1"},
        '{32'hFFFFFFFF, 5'd16, 1'b1, "-1"},
        '{32'h00ABCDEF, 5'd16, 1'b0, ""},
        '{32'hFFFFFFF6, 5'd10, 1'b0, ""},
        '{32'd12345,    5'd16, 1'b0, ""},
        '{32'd35,       5'd7,  1'b0, ""},
        '{32'd255,      5'd15, 1'b0, ""},
        '{32'd1000,     5'd9,  1'b0, ""},
        '{32'h80000000, 5'd5,  1'b0, ""},
        '{32'h12345678, 5'd0,  1'b1, ""},
        '{32'hFFFFFFFF, 5'd1,  1'b1, ""},
        '{32'd0,        5'd17, 1'b1, ""},
        '{32'h80000000, 5'd31, 1'b1, ""}
    };

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected characters of one integer in one base, least significant digit found first
    function automatic void spell_integer(input logic [VALUE_BITS-1:0] value,
                                          input logic [4:0] radix);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] base;
        logic [3:0]            digits [$];
        t_char_beat            beat;
        if (radix < sirs_pkg::RADIX_MIN || radix > sirs_pkg::RADIX_MAX) begin
            beat.code = '0;
            beat.last = 1'b1;
            beat.bad  = 1'b1;
            pending_chars = {pending_chars, beat};
            return;
        end
        base = VALUE_BITS'(radix);
        // true magnitude, the most negative value included
        mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        do begin
            digits = {digits, 4'(mag % base)};
            mag = mag / base;
        end while (mag != 0);
        beat.bad = 1'b0;
        if (value[VALUE_BITS-1]) begin
            beat.code = sirs_pkg::MINUS_CODE;
            beat.last = 1'b0;
            pending_chars = {pending_chars, beat};
        end
        for (int i = digits.size() - 1; i >= 0; i--) begin
            beat.code = (digits[i] < 4'd10) ? 7'h30 + 7'(digits[i]) : 7'h37 + 7'(digits[i]);
            beat.last = (i == 0);
            pending_chars = {pending_chars, beat};
        end
    endfunction

    // offer one integer, wait for its beat, then queue what it should produce
    task automatic send_int(input logic [VALUE_BITS-1:0] value, input logic [4:0] radix,
                            input bit typed, input string text);
        t_char_beat beat;
        byte        ch;
        while (!calm && !hold_req && $urandom_range(99) < 32) begin
            num_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        num_ch.valid <= 1'b1;
        num_ch.value <= value;
        num_ch.radix <= radix;
        do @(posedge i_clk); while (!num_ch.ready);
        ints_sent++;
        if (radix < sirs_pkg::RADIX_MIN || radix > sirs_pkg::RADIX_MAX)
            bad_sent++;
        if (!typed) begin
            spell_integer(value, radix);
        end else if (text.len() == 0) begin
            beat = '{code: 7'd0, last: 1'b1, bad: 1'b1};
            pending_chars = {pending_chars, beat};
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                ch = text[i];
                beat = '{code: ch[6:0], last: (i == text.len() - 1), bad: 1'b0};
                pending_chars = {pending_chars, beat};
            end
        end
    endtask

    // character sink: random stalls, one long hold-off on request
    initial begin : char_sink
        txt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                txt_ch.ready <= 1'b0;
                for (int k = 1; k < HOLD_CYCLES; k++)
                    @(posedge i_clk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
            end else begin
                txt_ch.ready <= calm || ($urandom_range(99) >= 32);
            end
        end
    end

    // compare each character beat with the oldest expectation
    always @(posedge i_clk) begin : char_check
        t_char_beat want;
        if (i_rst_n === 1'b1 && txt_ch.valid === 1'b1 && txt_ch.ready === 1'b1) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected beat code %h last %b bad %b", $realtime,
                             txt_ch.char_code, txt_ch.last_char, txt_ch.bad_radix);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (txt_ch.char_code !== want.code || txt_ch.last_char !== want.last ||
                    txt_ch.bad_radix !== want.bad) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: expected code %h last %b bad %b, got code %h last %b bad %b",
                                 $realtime, want.code, want.last, want.bad,
                                 txt_ch.char_code, txt_ch.last_char, txt_ch.bad_radix);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((num_ch.valid === 1'b1 && num_ch.ready === 1'b1) ||
            (txt_ch.valid === 1'b1 && txt_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d characters outstanding",
                     IDLE_LIMIT, pending_chars.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // reset, directed table, random integers, drain
    initial begin : stimulus
        logic [VALUE_BITS-1:0] value;
        logic [4:0]            radix;
        longint unsigned       pw;
        int                    steps;
        i_rst_n      <= 1'b0;
        num_ch.valid <= 1'b0;
        num_ch.value <= '0;
        num_ch.radix <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_int(directed_rows[k].value, directed_rows[k].radix,
                     directed_rows[k].typed, directed_rows[k].text);

        for (int n = 0; n < N_RANDOM; n++) begin
            // one long sink hold-off, later a stretch with no stalls on either side
            if (n == 120)
                hold_req = 1'b1;
            calm = (n >= 300 && n < 380);

            // mostly legal bases, some of every illegal one
            if ($urandom_range(99) < 10)
                radix = ($urandom_range(3) == 0) ? 5'($urandom_range(1)) :
                                                   5'($urandom_range(31, 17));
            else
                radix = 5'($urandom_range(16, 2));

            case ($urandom_range(5))
                0: value = $urandom;
                1: value = $urandom_range(40);
                2: value = -VALUE_BITS'($urandom_range(40, 1));
                3: begin
                    value = $urandom >> $urandom_range(31);
                    if ($urandom_range(1))
                        value = -value;
                end
                4: begin
                    case ($urandom_range(3))
                        0: value = 32'h80000000;
                        1: value = 32'h7FFFFFFF;
                        2: value = 32'h80000001;
                        default: value = 32'hFFFFFFFF;
                    endcase
                end
                default: begin
                    // powers of the base and one below, where the digit count steps
                    pw    = 1;
                    steps = $urandom_range(31);
                    while (steps > 0 && pw * radix <= 64'h80000000) begin
                        pw = pw * radix;
                        steps--;
                    end
                    value = VALUE_BITS'(pw) - VALUE_BITS'($urandom_range(1));
                    if ($urandom_range(1))
                        value = -value;
                end
            endcase
            send_int(value, radix, 1'b0, "");
        end
        num_ch.valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("converted %0d integers (%0d with an illegal base) into %0d characters",
                 ints_sent, bad_sent, chars_seen);
        $display("bases 0 to 31, sink hold-off of %0d cycles %s, %0d mismatches",
                 HOLD_CYCLES, hold_done ? "done" : "missed", mismatches);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
design/sirs_pkg.sv
design/sirs_if.sv
design/sirs_front.sv
design/sirs_queue.sv
design/sirs_back.sv
design/signed_integer_to_radix_string.sv
sim/signed_integer_to_radix_string_test.sv
